>>> rtl/arp_cache_responder_assert.svh
// Assertion macros used by the ARP cache engine
`ifndef ARP_CACHE_RESPONDER_ASSERT_SVH
`define ARP_CACHE_RESPONDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ARPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ARPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/arpc_pkg.sv
// Types and constants for the ARP cache and responder
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    localparam int            CFG_DATA_W    = 48;
    localparam int            CFG_INDEX_W   = 1;
    localparam logic          CFG_OWN_IP    = 1'b0;
    localparam logic          CFG_OWN_MAC   = 1'b1;

    localparam logic [10:0]   MIN_ARP_LEN   = 11'd28;
    localparam logic [15:0]   HW_ETHERNET   = 16'h0001;
    localparam logic [15:0]   PROTO_IPV4    = 16'h0800;
    localparam logic [15:0]   OP_REQUEST    = 16'h0001;
    localparam logic          KIND_LOOKUP   = 1'b1;
    localparam logic [47:0]   MAC_BROADCAST = {48{1'b1}};

    localparam int            QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        RES_HIT   = 2'd0,
        RES_MISS  = 2'd1,
        RES_REPLY = 2'd2
    } t_result_kind;

    typedef enum logic [1:0] {
        CMD_LOOKUP      = 2'd0,
        CMD_LEARN       = 2'd1,
        CMD_LEARN_REPLY = 2'd2
    } t_cmd_op;

    typedef enum logic [1:0] {
        ENG_IDLE   = 2'd0,
        ENG_SCAN   = 2'd1,
        ENG_WRITE  = 2'd2,
        ENG_RESULT = 2'd3
    } t_eng_state;

    typedef struct packed {
        logic        kind;
        logic [10:0] packet_length;
        logic [15:0] hw_type;
        logic [15:0] ptype;
        logic [15:0] opcode;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [31:0] tgt_ip;
        logic [31:0] query_ip;
    } t_in_item;

    typedef struct packed {
        t_result_kind result_kind;
        logic [47:0]  peer_mac;
        logic [31:0]  peer_ip;
    } t_out_item;

    typedef struct packed {
        t_cmd_op     op;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_cmd;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry;

endpackage

`default_nettype wire

>>> rtl/arp_cache_responder.sv
// Top level of the ARP cache and responder
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg       input      i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// The engine holds one command at a time and walks the stored pairs linearly, one entry
// per cycle, stopping early on a hit; a learn that triggers a reply also forms a result.
// Dropped packets end in the front end.
// Reset is synchronous, active low; it empties the table and clears own IP.
// Two commands wait in the queue and one in the front end; then the input stalls.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_responder
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 32
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    input  wire t_in_item               i_in_item,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output t_out_item                   o_out_item,
    input  wire logic                   i_out_stall
);

    logic f_cmd_valid, f_cmd_stall;
    t_cmd f_cmd;
    logic q_pop_valid, q_pop_en;
    t_cmd q_pop_cmd;

    arpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (f_cmd_valid),
        .o_cmd       (f_cmd),
        .i_cmd_stall (f_cmd_stall)
    );

    arpc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_cmd_valid),
        .i_push_cmd   (f_cmd),
        .o_push_stall (f_cmd_stall),
        .o_pop_valid  (q_pop_valid),
        .o_pop_cmd    (q_pop_cmd),
        .i_pop_en     (q_pop_en)
    );

    arpc_engine #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_pop_valid),
        .i_cmd       (q_pop_cmd),
        .o_cmd_pop   (q_pop_en),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

>>> rtl/arpc_front.sv
// Front end: takes input items, filters packets and forms engine commands
`timescale 1ns / 1ps
`default_nettype none

module arpc_front
    import arpc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    input  wire t_in_item               i_in_item,
    output logic                        o_in_stall,
    output logic                        o_cmd_valid,
    output t_cmd                        o_cmd,
    input  wire logic                   i_cmd_stall
);

    logic [31:0] r_own_ip;
    logic        r_cmd_valid, n_cmd_valid;
    t_cmd        r_cmd, n_cmd;
    t_cmd        cls_cmd;
    logic        cls_keep;
    logic        accept;

    assign o_in_stall  = r_cmd_valid && i_cmd_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        cls_cmd.ip  = i_in_item.src_ip;
        cls_cmd.mac = i_in_item.src_mac;
        if (i_in_item.kind == KIND_LOOKUP) begin
            cls_cmd.op = CMD_LOOKUP;
            cls_cmd.ip = i_in_item.query_ip;
            cls_keep   = 1'b1;
        end else begin
            cls_keep = (i_in_item.packet_length >= MIN_ARP_LEN)
                    && (i_in_item.hw_type == HW_ETHERNET)
                    && (i_in_item.ptype == PROTO_IPV4);
            if (i_in_item.opcode == OP_REQUEST && i_in_item.tgt_ip == r_own_ip) begin
                cls_cmd.op = CMD_LEARN_REPLY;
            end else begin
                cls_cmd.op = CMD_LEARN;
            end
        end
    end

    always_comb begin
        n_cmd_valid = r_cmd_valid;
        n_cmd       = r_cmd;
        if (r_cmd_valid && !i_cmd_stall) begin
            n_cmd_valid = 1'b0;
        end
        if (accept) begin
            n_cmd_valid = cls_keep;
            n_cmd       = cls_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip    <= '0;
            r_cmd_valid <= 1'b0;
        end else begin
            r_cmd_valid <= n_cmd_valid;
            if (i_cfg_wr_en && i_cfg_index == CFG_OWN_IP) begin
                r_own_ip <= i_cfg_data[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

`default_nettype wire

>>> rtl/arpc_queue.sv
// Short command queue between the front end and the cache engine
`timescale 1ns / 1ps
`default_nettype none

module arpc_queue
    import arpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    input  wire t_cmd i_push_cmd,
    output logic      o_push_stall,
    output logic      o_pop_valid,
    output t_cmd      o_pop_cmd,
    input  wire logic i_pop_en
);

    localparam int Q_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd               r_store [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               push, pop;

    assign o_push_stall = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_store[r_rd_ptr];
    assign push         = i_push_valid && !o_push_stall;
    assign pop          = i_pop_en && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_store[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/arpc_engine.sv
// Cache engine: walks the pair table, learns pairs and forms result items
`timescale 1ns / 1ps
`default_nettype none

`include "arp_cache_responder_assert.svh"

module arpc_engine
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 32
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  wire logic i_out_stall
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    t_entry           r_mem [CACHE_ENTRIES];
    t_eng_state       r_state, n_state;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_idx;
    t_entry           r_rd_entry;
    logic             r_found;
    logic [IDX_W-1:0] r_slot;
    logic [47:0]      r_found_mac;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             scan_hit, scan_end, out_free;
    logic             rd_en, wr_en, cnt_inc, load_out;
    logic [IDX_W-1:0] wr_addr;
    t_out_item        res_item;

    assign scan_hit    = r_pend && (r_rd_entry.ip == r_cmd.ip);
    assign scan_end    = scan_hit || (r_idx == r_count);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ENG_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = ENG_SCAN;
                end
            end
            ENG_SCAN: begin
                if (scan_end) begin
                    n_state = (r_cmd.op == CMD_LOOKUP) ? ENG_RESULT : ENG_WRITE;
                end
            end
            ENG_WRITE: begin
                n_state = (r_cmd.op == CMD_LEARN_REPLY) ? ENG_RESULT : ENG_IDLE;
            end
            ENG_RESULT: begin
                if (out_free) begin
                    n_state = ENG_IDLE;
                end
            end
            default: n_state = ENG_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        cnt_inc   = 1'b0;
        wr_addr   = r_slot;
        load_out  = 1'b0;
        unique case (r_state)
            ENG_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            ENG_SCAN: begin
                rd_en = !scan_hit && (r_idx < r_count);
            end
            ENG_WRITE: begin
                if (r_found) begin
                    wr_en = 1'b1;
                end else if (r_count < CNT_W'(CACHE_ENTRIES)) begin
                    wr_en   = 1'b1;
                    cnt_inc = 1'b1;
                    wr_addr = r_count[IDX_W-1:0];
                end
            end
            ENG_RESULT: begin
                load_out = out_free;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        res_item.peer_ip = r_cmd.ip;
        if (r_cmd.op != CMD_LOOKUP) begin
            res_item.result_kind = RES_REPLY;
            res_item.peer_mac    = r_cmd.mac;
        end else if (r_found) begin
            res_item.result_kind = RES_HIT;
            res_item.peer_mac    = r_found_mac;
        end else begin
            res_item.result_kind = RES_MISS;
            res_item.peer_mac    = MAC_BROADCAST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ENG_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop) begin
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (r_state == ENG_SCAN) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (scan_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (cnt_inc) begin
                r_count <= r_count + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (rd_en) begin
            r_pend_idx <= r_idx[IDX_W-1:0];
        end
        if (scan_hit) begin
            r_slot      <= r_pend_idx;
            r_found_mac <= r_rd_entry.mac;
        end
        if (load_out) begin
            r_out <= res_item;
        end
    end

    // pair table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_cmd.ip, r_cmd.mac};
        end
        if (rd_en) begin
            r_rd_entry <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    `ARPC_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(CACHE_ENTRIES), "fill count past table size")
    `ARPC_ASSERT_IMP(a_idx_bound, r_state == ENG_SCAN, r_idx <= r_count, "scan index past fill count")
    `ARPC_ASSERT_IMP(a_hit_range, scan_hit, CNT_W'(r_pend_idx) < r_count, "hit on unfilled entry")
    `ARPC_ASSERT_NXT(a_count_step, 1'b1, (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1), "fill count moved by more than one")
    `ARPC_ASSERT_NXT(a_pop_scan, o_cmd_pop, r_state == ENG_SCAN, "popped command not scanned")

endmodule

`default_nettype wire
